[hdl/etps_pkg.sv]
`timescale 1ns / 1ps

package etps_pkg;

	localparam int MAX_WINDOW   = 4096;
	localparam int WIN_W        = $clog2(MAX_WINDOW + 1);  // holds the full window length
	localparam int OFF_W        = $clog2(MAX_WINDOW);      // offsets within the window
	localparam int SAMPLE_W     = 16;
	localparam int COUNT_W      = 32;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 1;
	localparam int PEAK_OFF_W   = 12;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd32768;
	localparam logic [WIN_W-1:0]    WINDOW_RESET    = WIN_W'(64);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENERGY_THRESHOLD = 1'b0,
		REG_WINDOW_LENGTH    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] energy_sample;
		logic [SAMPLE_W-1:0] sync_metric;
	} sample_t;

	typedef struct packed {
		logic [PEAK_OFF_W-1:0] peak_offset;
		logic [SAMPLE_W-1:0]   peak_value;
		logic [COUNT_W-1:0]    detect_index;
	} report_t;

	// Settings handed to the search logic; the window is already clamped.
	typedef struct packed {
		logic [SAMPLE_W-1:0] threshold;
		logic [WIN_W-1:0]    window;
	} search_cfg_t;

	function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] w;
		begin
			w = value & CFG_DATA_W'(13'h1FFF);
			if (w == '0)
				w = CFG_DATA_W'(1);
			if (w > CFG_DATA_W'(MAX_WINDOW))
				w = CFG_DATA_W'(MAX_WINDOW);
			return WIN_W'(w);
		end
	endfunction

endpackage

[hdl/etps_if.sv]
`timescale 1ns / 1ps

interface etps_sample_if import etps_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface etps_report_if import etps_pkg::*; ();
	logic    valid;
	logic    ready;
	report_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/energy_trigger_peak_search_core.sv]
`timescale 1ns / 1ps

// Energy-triggered packet detector with a sync-peak search.
// The samples channel takes one word per cycle: an energy value and a sync
// metric. An energy value at or above the threshold opens a window of
// window_length samples; when it closes, one word goes out on the reports
// channel with the peak offset, the peak metric and the detection index.
// Samples are then ignored until the packet starting at the peak has passed.
// Throughput is one sample per cycle unless the receiver stalls. A sample is
// held in an input register and evaluated once the output register is empty
// or being taken; the search state is then updated and any report is loaded
// into the output register. When the receiver stalls, the output register
// holds its report and the input register keeps its sample; samples.ready
// drops once both are full. Reset clears the search state, the sample count
// and both stages, and puts the threshold at 32768 and the window length at
// 64. Registers are to be written by the user through cfg_we, cfg_index and
// cfg_data only while no sample is in flight; the block does not enforce it.
module energy_trigger_peak_search_core import etps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	etps_sample_if.sink            samples,
	etps_report_if.source          reports,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	search_cfg_t cfg_q;
	logic        valid_s1;
	sample_t     sample_s1;
	logic        out_valid_q;
	report_t     out_report_q;
	logic        advance;
	logic        step;
	logic        found;
	report_t     report;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.window    <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENERGY_THRESHOLD: cfg_q.threshold <= cfg_data;
				REG_WINDOW_LENGTH:    cfg_q.window    <= clamp_window(cfg_data);
				default: ;
			endcase
		end
	end

	assign advance       = !out_valid_q || reports.ready;
	assign step          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid)
			sample_s1 <= samples.payload;
	end

	etps_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.found  (found),
		.report (report)
	);

	// The output word is replaced only when it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && found;
		end
	end

	always_ff @(posedge clk) begin
		if (step && found)
			out_report_q <= report;
	end

	assign reports.valid   = out_valid_q;
	assign reports.payload = out_report_q;

endmodule

[hdl/etps_search.sv]
`timescale 1ns / 1ps

module etps_search import etps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  sample_t     sample,
	input  search_cfg_t cfg,
	output logic        found,
	output report_t     report
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SEARCH = 2'd1,
		ST_HOLD   = 2'd2
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [OFF_W-1:0]    pos_q, pos_n;
	logic [OFF_W-1:0]    best_off_q, best_off_n;
	logic [SAMPLE_W-1:0] best_q, best_n;
	logic [OFF_W-1:0]    hold_q, hold_n;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  det_q, det_n;
	logic                take;

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		best_off_n = best_off_q;
		best_n     = best_q;
		hold_n     = hold_q;
		det_n      = det_q;
		take       = 1'b0;
		found      = 1'b0;

		case (phase_q)
			ST_SEARCH: begin
				take = 1'b1;
			end
			ST_HOLD: begin
				if (hold_q != '0)
					hold_n = hold_q - OFF_W'(1);
				if (hold_n == '0)
					phase_n = ST_IDLE;
			end
			default: begin
				// An unused code behaves as idle.
				phase_n = ST_IDLE;
				if (sample.energy_sample >= cfg.threshold) begin
					det_n      = count_q;
					pos_n      = '0;
					best_off_n = '0;
					best_n     = sample.sync_metric;
					phase_n    = ST_SEARCH;
					take       = 1'b1;
				end
			end
		endcase

		if (take) begin
			// Strictly greater, so the earliest peak wins a tie.
			if (pos_n != '0 && sample.sync_metric > best_n) begin
				best_n     = sample.sync_metric;
				best_off_n = pos_n;
			end
			if ({1'b0, pos_n} + WIN_W'(1) >= cfg.window) begin
				found   = 1'b1;
				pos_n   = '0;
				hold_n  = best_off_n;
				phase_n = (best_off_n == '0) ? ST_IDLE : ST_HOLD;
			end else begin
				pos_n = pos_n + OFF_W'(1);
			end
		end
	end

	assign report.peak_offset  = PEAK_OFF_W'(best_off_n);
	assign report.peak_value   = best_n;
	assign report.detect_index = det_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ST_IDLE;
			pos_q      <= '0;
			best_off_q <= '0;
			best_q     <= '0;
			hold_q     <= '0;
			count_q    <= '0;
			det_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			best_off_q <= best_off_n;
			best_q     <= best_n;
			hold_q     <= hold_n;
			count_q    <= count_q + COUNT_W'(1);
			det_q      <= det_n;
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb import etps_pkg::*; ();

	typedef enum logic [1:0] {ARMED, SEARCHING, HOLDING} detector_phase_t;
	typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		cfg_reg_t            which;
		logic [15:0]         value;
		logic [15:0]         energy;
		logic [15:0]         metric;
		report_t             want;
	} step_t;

	localparam int LONG_WINDOW = 256;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	etps_sample_if samples();
	etps_report_if reports();

	energy_trigger_peak_search_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.reports   (reports),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the detector state and its settings.
	detector_phase_t det_phase;
	logic [12:0]     win_pos;
	logic [12:0]     hold_left;
	logic [11:0]     best_off;
	logic [15:0]     best_val;
	logic [31:0]     sample_idx;
	logic [31:0]     detect_idx;
	logic [15:0]     thr_setting;
	logic [12:0]     win_setting;

	report_t pending_reports[$];
	int      failures = 0;
	bit      steady = 1'b0;
	bit      stall_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	// Advances the detector by one sample and tells whether a report falls out.
	task automatic track_detector(input logic [15:0] energy, input logic [15:0] metric,
			output bit fired, output report_t rep);
		int span;
		bit take;
		fired = 1'b0;
		take = 1'b0;
		rep = '0;
		span = (win_setting == 0) ? 1 :
			((win_setting > MAX_WINDOW) ? MAX_WINDOW : int'(win_setting));
		case (det_phase)
			SEARCHING: take = 1'b1;
			HOLDING: begin
				if (hold_left > 0)
					hold_left--;
				if (hold_left == 0)
					det_phase = ARMED;
			end
			default: begin
				det_phase = ARMED;
				if (energy >= thr_setting) begin
					detect_idx = sample_idx;
					win_pos = '0;
					best_off = '0;
					best_val = metric;
					det_phase = SEARCHING;
					take = 1'b1;
				end
			end
		endcase
		if (take) begin
			// Only a strictly larger metric moves the peak, so the earliest one wins ties.
			if (win_pos != 0 && metric > best_val) begin
				best_val = metric;
				best_off = win_pos[11:0];
			end
			if (int'(win_pos) + 1 >= span) begin
				fired = 1'b1;
				rep.peak_offset = best_off;
				rep.peak_value = best_val;
				rep.detect_index = detect_idx;
				win_pos = '0;
				hold_left = {1'b0, best_off};
				det_phase = (best_off == 0) ? ARMED : HOLDING;
			end else begin
				win_pos++;
			end
		end
		sample_idx++;
	endtask

	task automatic send_sample(input logic [15:0] energy, input logic [15:0] metric,
			input bit typed, input report_t typed_rep);
		sample_t word;
		bit      fired;
		report_t rep;
		word.energy_sample = energy;
		word.sync_metric = metric;
		while (!steady && $urandom_range(99) < 19) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.payload <= word;
		do @(posedge clk); while (!samples.ready);
		track_detector(energy, metric, fired, rep);
		if (typed)
			pending_reports.push_back(typed_rep);
		else if (fired)
			pending_reports.push_back(rep);
	endtask

	// Stops offering words and lets the pipeline empty before a register write.
	task automatic drain();
		int waited;
		waited = 0;
		samples.valid <= 1'b0;
		while (pending_reports.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (which == REG_ENERGY_THRESHOLD)
			thr_setting = value;
		else
			win_setting = value[12:0];
	endtask

	function automatic step_t smp(input logic [15:0] energy, input logic [15:0] metric);
		step_t s;
		s = '0;
		s.kind = ROW_SAMPLE;
		s.energy = energy;
		s.metric = metric;
		return s;
	endfunction

	function automatic step_t chk(input logic [15:0] energy, input logic [15:0] metric,
			input logic [11:0] off, input logic [15:0] val, input logic [31:0] idx);
		step_t s;
		s = smp(energy, metric);
		s.kind = ROW_CHECKED;
		s.want.peak_offset = off;
		s.want.peak_value = val;
		s.want.detect_index = idx;
		return s;
	endfunction

	function automatic step_t wr(input cfg_reg_t which, input logic [15:0] value);
		step_t s;
		s = '0;
		s.kind = ROW_WRITE;
		s.which = which;
		s.value = value;
		return s;
	endfunction

	// Receiver: random stalls, one long hold-off when asked for.
	initial begin
		reports.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				reports.ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_request = 1'b0;
			end else begin
				reports.ready <= steady || ($urandom_range(99) >= 19);
			end
		end
	end

	always @(posedge clk) begin : watch_reports
		report_t want;
		if (arst_n && reports.valid && reports.ready) begin
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected report: offset %0d value %h index %0d",
					reports.payload.peak_offset, reports.payload.peak_value,
					reports.payload.detect_index));
			end else begin
				want = pending_reports.pop_front();
				if (reports.payload.peak_offset !== want.peak_offset ||
						reports.payload.peak_value !== want.peak_value ||
						reports.payload.detect_index !== want.detect_index) begin
					note_failure($sformatf(
						"report mismatch: offset exp %0d got %0d, value exp %h got %h, index exp %0d got %0d",
						want.peak_offset, reports.payload.peak_offset,
						want.peak_value, reports.payload.peak_value,
						want.detect_index, reports.payload.detect_index));
				end
			end
		end
	end

	initial begin : stimulus
		step_t       steps [0:27];
		int          random_items;
		int          phase_no;
		int          n_items;
		int          k;
		logic [15:0] e;
		logic [15:0] m;
		logic [15:0] tdata;
		logic [15:0] wdata;

		samples.valid <= 1'b0;
		samples.payload <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ENERGY_THRESHOLD;
		cfg_data <= '0;
		arst_n <= 1'b0;
		det_phase = ARMED;
		win_pos = '0;
		hold_left = '0;
		best_off = '0;
		best_val = '0;
		sample_idx = '0;
		detect_idx = '0;
		thr_setting = THRESHOLD_RESET;
		win_setting = 13'd64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		steps = '{
			smp(16'h7FFF, 16'hFFFF),
			wr(REG_WINDOW_LENGTH, 16'h0000),
			chk(16'hFFFF, 16'hFFFF, 12'd0, 16'hFFFF, 32'd1),
			chk(16'h8000, 16'h0000, 12'd0, 16'h0000, 32'd2),
			smp(16'h7FFF, 16'h1234),
			wr(REG_ENERGY_THRESHOLD, 16'h0000),
			chk(16'h0000, 16'h1234, 12'd0, 16'h1234, 32'd4),
			wr(REG_WINDOW_LENGTH, 16'h0003),
			smp(16'h0000, 16'h0005),
			smp(16'h0000, 16'h0009),
			smp(16'h0000, 16'h0009),
			smp(16'hFFFF, 16'hFFFF),
			wr(REG_WINDOW_LENGTH, 16'h1FFF),
			smp(16'h0000, 16'h0007),
			smp(16'h0000, 16'h0008),
			wr(REG_WINDOW_LENGTH, 16'h0002),
			smp(16'h0000, 16'h0003),
			wr(REG_WINDOW_LENGTH, 16'hE003),
			smp(16'hFFFF, 16'h0000),
			wr(REG_ENERGY_THRESHOLD, 16'hFFFF),
			smp(16'hFFFE, 16'hFFFF),
			smp(16'hFFFF, 16'h0000),
			smp(16'h0000, 16'h0000),
			smp(16'h0000, 16'h0001),
			smp(16'hFFFF, 16'hFFFF),
			wr(REG_WINDOW_LENGTH, 16'h0001),
			smp(16'hFFFF, 16'hFFFF),
			chk(16'hFFFF, 16'hABCD, 12'd0, 16'hABCD, 32'd19)
		};
		foreach (steps[i]) begin
			case (steps[i].kind)
				ROW_WRITE: begin
					drain();
					write_reg(steps[i].which, steps[i].value);
				end
				ROW_CHECKED: send_sample(steps[i].energy, steps[i].metric, 1'b1, steps[i].want);
				default: send_sample(steps[i].energy, steps[i].metric, 1'b0, '0);
			endcase
		end

		random_items = 0;
		for (phase_no = 0; random_items < 1620; phase_no++) begin
			drain();
			steady = (phase_no >= 6 && phase_no <= 8);
			if (phase_no == 0) begin
				// One long window from an armed detector, peak on its last sample.
				write_reg(REG_ENERGY_THRESHOLD, 16'hFFFF);
				write_reg(REG_WINDOW_LENGTH, 16'h0001);
				while (det_phase != ARMED)
					send_sample(16'h0000, 16'($urandom), 1'b0, '0);
				drain();
				write_reg(REG_ENERGY_THRESHOLD, 16'h0000);
				write_reg(REG_WINDOW_LENGTH, 16'(LONG_WINDOW));
				for (k = 0; k < LONG_WINDOW; k++) begin
					send_sample(16'($urandom), (k == LONG_WINDOW - 1) ? 16'hFFFF :
						16'($urandom_range(16'hFFFE, 0)), 1'b0, '0);
					random_items++;
				end
				for (k = 0; k < LONG_WINDOW - 1; k++) begin
					send_sample(16'($urandom), 16'($urandom), 1'b0, '0);
					random_items++;
				end
			end else begin
				if (phase_no == 3) begin
					// Every word gives a report, so a held-off receiver backs the block up.
					tdata = 16'h0000;
					wdata = 16'($urandom_range(1, 0));
				end else begin
					k = $urandom_range(9);
					if (k == 0)
						tdata = 16'h0000;
					else if (k == 1)
						tdata = 16'hFFFF;
					else if (k < 6)
						tdata = 16'($urandom);
					else
						tdata = 16'($urandom_range(16'hE000, 16'h2000));
					k = $urandom_range(19);
					if (k == 0)
						wdata = 16'h0000;
					else if (k == 1)
						wdata = 16'h0001;
					else if (k < 17)
						wdata = 16'($urandom_range(12, 2));
					else
						wdata = 16'($urandom_range(80, 13));
					wdata = wdata | (16'($urandom_range(7, 0)) << 13);
				end
				if (phase_no == 3 || $urandom_range(9) >= 3)
					write_reg(REG_ENERGY_THRESHOLD, tdata);
				write_reg(REG_WINDOW_LENGTH, wdata);
				stall_request = (phase_no == 3);
				n_items = (phase_no == 3) ? 250 : $urandom_range(120, 40);
				repeat (n_items) begin
					k = $urandom_range(99);
					if (k < 12)
						e = 16'($urandom_range(16'hFFFF, thr_setting));
					else if (k < 16)
						e = thr_setting;
					else if (k < 20)
						e = thr_setting - 16'd1;
					else if (k < 35 || thr_setting == 0)
						e = 16'($urandom);
					else
						e = 16'($urandom_range(thr_setting - 1, 0));
					k = $urandom_range(99);
					if (k < 25)
						m = 16'($urandom_range(3, 0));
					else if (k < 30)
						m = 16'hFFFF;
					else if (k < 33)
						m = 16'h0000;
					else
						m = 16'($urandom);
					random_items++;
					send_sample(e, m, 1'b0, '0);
				end
			end
		end

		steady = 1'b0;
		drain();
		repeat (16) @(posedge clk);
		if (pending_reports.size() != 0)
			note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/etps_pkg.sv
hdl/etps_if.sv
hdl/etps_search.sv
hdl/energy_trigger_peak_search_core.sv
test/tb.sv
